### rtl/core/triangle_normal_bounds_unit_defines.svh
// Assertion macros for the triangle normal and bounds unit.
`ifndef TRIANGLE_NORMAL_BOUNDS_UNIT_DEFINES_SVH
`define TRIANGLE_NORMAL_BOUNDS_UNIT_DEFINES_SVH

// Checks that a condition implies a consequence in the same cycle.
`define TNB_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("triangle_normal_bounds_unit same-cycle check failed");

// Checks that a condition implies a consequence in the next cycle.
`define TNB_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("triangle_normal_bounds_unit next-cycle check failed");

`endif

### rtl/core/tnb_pkg.sv
// Shared constants and types for the triangle normal and bounds unit.
package tnb_pkg;

    localparam int COORD_BITS  = 16;
    localparam int NORMAL_BITS = 16;
    localparam int EDGE_BITS   = COORD_BITS + 1;
    localparam int CROSS_BITS  = 2 * EDGE_BITS + 1;
    localparam int MAG_BITS    = 30;
    localparam int SH_BITS     = $clog2(CROSS_BITS - MAG_BITS + 1);
    localparam int MUL_BITS    = 32;
    localparam int ACC_BITS    = 2 * MUL_BITS;
    localparam int LEN_BITS    = 32;
    localparam int SQRT_LAST   = 31;
    localparam int DIV_LAST    = NORMAL_BITS - 1;
    localparam int CNT_BITS    = $clog2(SQRT_LAST + 1);
    localparam int RADIUS_BITS = 16;

    localparam logic signed [COORD_BITS-1:0] COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
    localparam logic signed [COORD_BITS-1:0] COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

    typedef enum logic [3:0] {
        S_IDLE,
        S_CROSS,
        S_SCALE,
        S_NSUM,
        S_NSQRT,
        S_DIV,
        S_RSUM,
        S_RSQRT,
        S_DONE
    } state_t;

endpackage

### rtl/core/triangle_normal_bounds_unit.sv
// Triangle face normal, running bounding box center and radius, on one shared multiplier.
// Steps: cross product, scale, two sums of squares, two 32-step square roots and three 16-step
// divisions; a degenerate triangle skips the normal sum, root and divisions.
// A new triangle is accepted only once the result word has been taken; an output stall delays that.
// Reset: rst_n clears the sequencer to idle and the bounding box to empty.
`include "triangle_normal_bounds_unit_defines.svh"

module triangle_normal_bounds_unit
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic                                   new_mesh,
    input  logic signed [tnb_pkg::COORD_BITS-1:0]  a_x,
    input  logic signed [tnb_pkg::COORD_BITS-1:0]  a_y,
    input  logic signed [tnb_pkg::COORD_BITS-1:0]  a_z,
    input  logic signed [tnb_pkg::COORD_BITS-1:0]  b_x,
    input  logic signed [tnb_pkg::COORD_BITS-1:0]  b_y,
    input  logic signed [tnb_pkg::COORD_BITS-1:0]  b_z,
    input  logic signed [tnb_pkg::COORD_BITS-1:0]  c_x,
    input  logic signed [tnb_pkg::COORD_BITS-1:0]  c_y,
    input  logic signed [tnb_pkg::COORD_BITS-1:0]  c_z,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic signed [tnb_pkg::NORMAL_BITS-1:0] normal_x,
    output logic signed [tnb_pkg::NORMAL_BITS-1:0] normal_y,
    output logic signed [tnb_pkg::NORMAL_BITS-1:0] normal_z,
    output logic                                   degenerate,
    output logic signed [tnb_pkg::COORD_BITS-1:0]  center_x,
    output logic signed [tnb_pkg::COORD_BITS-1:0]  center_y,
    output logic signed [tnb_pkg::COORD_BITS-1:0]  center_z,
    output logic [tnb_pkg::RADIUS_BITS-1:0]        radius
);

    tnb_pkg::state_t state_reg;
    tnb_pkg::state_t state_next;

    logic [2:0]                         idx_reg;
    logic                               phase_reg;
    logic [tnb_pkg::CNT_BITS-1:0]       cnt_reg;

    logic signed [tnb_pkg::COORD_BITS-1:0]  box_low_reg [3];
    logic signed [tnb_pkg::COORD_BITS-1:0]  box_high_reg [3];

    logic signed [tnb_pkg::EDGE_BITS-1:0]   e1_reg [3];
    logic signed [tnb_pkg::EDGE_BITS-1:0]   e2_reg [3];
    logic signed [tnb_pkg::ACC_BITS-1:0]    prod_reg;
    logic signed [tnb_pkg::ACC_BITS-1:0]    acc_reg;
    logic signed [tnb_pkg::CROSS_BITS-1:0]  cr_reg [3];
    logic [tnb_pkg::MAG_BITS-1:0]           mag_reg [3];
    logic                                   neg_reg [3];
    logic                                   degen_reg;
    logic [tnb_pkg::ACC_BITS-1:0]           sq_rem_reg;
    logic [tnb_pkg::ACC_BITS-1:0]           sq_root_reg;
    logic [tnb_pkg::LEN_BITS-1:0]           len_reg;
    logic [tnb_pkg::LEN_BITS-1:0]           div_rem_reg;
    logic [tnb_pkg::NORMAL_BITS-1:0]        quo_reg;
    logic signed [tnb_pkg::NORMAL_BITS-1:0] normal_reg [3];
    logic [tnb_pkg::RADIUS_BITS-1:0]        radius_reg;

    logic signed [tnb_pkg::COORD_BITS-1:0]  vin [3][3];
    logic signed [tnb_pkg::COORD_BITS-1:0]  low_new [3];
    logic signed [tnb_pkg::COORD_BITS-1:0]  high_new [3];
    logic signed [tnb_pkg::COORD_BITS:0]    box_sum [3];
    logic signed [tnb_pkg::COORD_BITS-1:0]  ctr [3];
    logic signed [tnb_pkg::COORD_BITS:0]    half_diag [3];

    logic signed [tnb_pkg::MUL_BITS-1:0]    mul_a;
    logic signed [tnb_pkg::MUL_BITS-1:0]    mul_b;
    logic                                   mul_last;

    logic [tnb_pkg::CROSS_BITS-1:0]         mag_full [3];
    logic [tnb_pkg::CROSS_BITS-1:0]         mag_or;
    logic [tnb_pkg::SH_BITS-1:0]            shift_amt;
    logic                                   degen_now;

    logic [tnb_pkg::ACC_BITS-1:0]           sq_bit;
    logic [tnb_pkg::ACC_BITS-1:0]           sq_trial;
    logic [tnb_pkg::ACC_BITS-1:0]           sq_rem_next;
    logic [tnb_pkg::ACC_BITS-1:0]           sq_root_next;

    logic                                   div_ge;
    logic [tnb_pkg::LEN_BITS-1:0]           div_diff;
    logic [tnb_pkg::NORMAL_BITS-1:0]        quo_next;
    logic [tnb_pkg::NORMAL_BITS-1:0]        quo_sat;
    logic signed [tnb_pkg::NORMAL_BITS-1:0] normal_new;

    logic                                   in_accept;

    assign in_accept = in_valid && !in_stall;

    always_comb
    begin
        vin[0][0] = a_x; vin[0][1] = a_y; vin[0][2] = a_z;
        vin[1][0] = b_x; vin[1][1] = b_y; vin[1][2] = b_z;
        vin[2][0] = c_x; vin[2][1] = c_y; vin[2][2] = c_z;
        for (int k = 0; k < 3; k++)
        begin
            low_new[k]  = new_mesh ? tnb_pkg::COORD_MAX : box_low_reg[k];
            high_new[k] = new_mesh ? tnb_pkg::COORD_MIN : box_high_reg[k];
            for (int i = 0; i < 3; i++)
            begin
                if (vin[i][k] < low_new[k])
                begin
                    low_new[k] = vin[i][k];
                end
                if (vin[i][k] > high_new[k])
                begin
                    high_new[k] = vin[i][k];
                end
            end
            box_sum[k] = (tnb_pkg::COORD_BITS+1)'(box_high_reg[k])
                       + (tnb_pkg::COORD_BITS+1)'(box_low_reg[k]);
            ctr[k]     = tnb_pkg::COORD_BITS'(box_sum[k] >>> 1);
            half_diag[k] = (tnb_pkg::COORD_BITS+1)'(box_high_reg[k])
                         - (tnb_pkg::COORD_BITS+1)'(ctr[k]);
        end
    end

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            tnb_pkg::S_CROSS:
            begin
                case (idx_reg)
                    3'd0:
                    begin
                        mul_a = tnb_pkg::MUL_BITS'(e1_reg[1]);
                        mul_b = tnb_pkg::MUL_BITS'(e2_reg[2]);
                    end
                    3'd1:
                    begin
                        mul_a = tnb_pkg::MUL_BITS'(e1_reg[2]);
                        mul_b = tnb_pkg::MUL_BITS'(e2_reg[1]);
                    end
                    3'd2:
                    begin
                        mul_a = tnb_pkg::MUL_BITS'(e1_reg[2]);
                        mul_b = tnb_pkg::MUL_BITS'(e2_reg[0]);
                    end
                    3'd3:
                    begin
                        mul_a = tnb_pkg::MUL_BITS'(e1_reg[0]);
                        mul_b = tnb_pkg::MUL_BITS'(e2_reg[2]);
                    end
                    3'd4:
                    begin
                        mul_a = tnb_pkg::MUL_BITS'(e1_reg[0]);
                        mul_b = tnb_pkg::MUL_BITS'(e2_reg[1]);
                    end
                    default:
                    begin
                        mul_a = tnb_pkg::MUL_BITS'(e1_reg[1]);
                        mul_b = tnb_pkg::MUL_BITS'(e2_reg[0]);
                    end
                endcase
            end
            tnb_pkg::S_NSUM:
            begin
                mul_a = $signed(tnb_pkg::MUL_BITS'(mag_reg[idx_reg[1:0]]));
                mul_b = mul_a;
            end
            tnb_pkg::S_RSUM:
            begin
                mul_a = tnb_pkg::MUL_BITS'(half_diag[idx_reg[1:0]]);
                mul_b = mul_a;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_last = phase_reg && (idx_reg == ((state_reg == tnb_pkg::S_CROSS) ? 3'd5 : 3'd2));

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            mag_full[k] = cr_reg[k][tnb_pkg::CROSS_BITS-1] ? tnb_pkg::CROSS_BITS'(-cr_reg[k])
                                                           : tnb_pkg::CROSS_BITS'(cr_reg[k]);
        end
        mag_or    = mag_full[0] | mag_full[1] | mag_full[2];
        degen_now = (mag_or == '0);
        shift_amt = '0;
        for (int b = tnb_pkg::MAG_BITS; b < tnb_pkg::CROSS_BITS; b++)
        begin
            if (mag_or[b])
            begin
                shift_amt = tnb_pkg::SH_BITS'(b - tnb_pkg::MAG_BITS + 1);
            end
        end
    end

    always_comb
    begin
        sq_bit   = tnb_pkg::ACC_BITS'(1) << {cnt_reg, 1'b0};
        sq_trial = sq_root_reg + sq_bit;
        if (sq_rem_reg >= sq_trial)
        begin
            sq_rem_next  = sq_rem_reg - sq_trial;
            sq_root_next = (sq_root_reg >> 1) + sq_bit;
        end
        else
        begin
            sq_rem_next  = sq_rem_reg;
            sq_root_next = sq_root_reg >> 1;
        end
    end

    always_comb
    begin
        div_ge     = (div_rem_reg >= len_reg);
        div_diff   = div_ge ? (div_rem_reg - len_reg) : div_rem_reg;
        quo_next   = {quo_reg[tnb_pkg::NORMAL_BITS-2:0], div_ge};
        quo_sat    = (quo_next[tnb_pkg::NORMAL_BITS-1]) ? {1'b0, {(tnb_pkg::NORMAL_BITS-1){1'b1}}}
                                                        : quo_next;
        normal_new = neg_reg[idx_reg[1:0]] ? -$signed(quo_sat) : $signed(quo_sat);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            tnb_pkg::S_IDLE:  if (in_valid) state_next = tnb_pkg::S_CROSS;
            tnb_pkg::S_CROSS: if (mul_last) state_next = tnb_pkg::S_SCALE;
            tnb_pkg::S_SCALE: state_next = degen_now ? tnb_pkg::S_RSUM : tnb_pkg::S_NSUM;
            tnb_pkg::S_NSUM:  if (mul_last) state_next = tnb_pkg::S_NSQRT;
            tnb_pkg::S_NSQRT: if (cnt_reg == '0) state_next = tnb_pkg::S_DIV;
            tnb_pkg::S_DIV:   if (cnt_reg == '0 && idx_reg == 3'd2) state_next = tnb_pkg::S_RSUM;
            tnb_pkg::S_RSUM:  if (mul_last) state_next = tnb_pkg::S_RSQRT;
            tnb_pkg::S_RSQRT: if (cnt_reg == '0) state_next = tnb_pkg::S_DONE;
            tnb_pkg::S_DONE:  if (!out_stall) state_next = tnb_pkg::S_IDLE;
            default:          state_next = tnb_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        in_stall  = (state_reg != tnb_pkg::S_IDLE);
        out_valid = (state_reg == tnb_pkg::S_DONE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tnb_pkg::S_IDLE;
            idx_reg   <= '0;
            phase_reg <= 1'b0;
            cnt_reg   <= '0;
            for (int k = 0; k < 3; k++)
            begin
                box_low_reg[k]  <= tnb_pkg::COORD_MAX;
                box_high_reg[k] <= tnb_pkg::COORD_MIN;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (in_accept)
            begin
                box_low_reg  <= low_new;
                box_high_reg <= high_new;
            end
            if (state_next != state_reg)
            begin
                idx_reg   <= '0;
                phase_reg <= 1'b0;
                cnt_reg   <= (state_next == tnb_pkg::S_DIV) ? tnb_pkg::CNT_BITS'(tnb_pkg::DIV_LAST)
                                                            : tnb_pkg::CNT_BITS'(tnb_pkg::SQRT_LAST);
            end
            else
            begin
                case (state_reg)
                    tnb_pkg::S_CROSS, tnb_pkg::S_NSUM, tnb_pkg::S_RSUM:
                    begin
                        phase_reg <= !phase_reg;
                        if (phase_reg)
                        begin
                            idx_reg <= idx_reg + 3'd1;
                        end
                    end
                    tnb_pkg::S_NSQRT, tnb_pkg::S_RSQRT:
                    begin
                        cnt_reg <= cnt_reg - tnb_pkg::CNT_BITS'(1);
                    end
                    tnb_pkg::S_DIV:
                    begin
                        if (cnt_reg == '0)
                        begin
                            cnt_reg <= tnb_pkg::CNT_BITS'(tnb_pkg::DIV_LAST);
                            idx_reg <= idx_reg + 3'd1;
                        end
                        else
                        begin
                            cnt_reg <= cnt_reg - tnb_pkg::CNT_BITS'(1);
                        end
                    end
                    default:
                    begin
                        phase_reg <= phase_reg;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            tnb_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    for (int k = 0; k < 3; k++)
                    begin
                        e1_reg[k] <= tnb_pkg::EDGE_BITS'(vin[1][k]) - tnb_pkg::EDGE_BITS'(vin[0][k]);
                        e2_reg[k] <= tnb_pkg::EDGE_BITS'(vin[2][k]) - tnb_pkg::EDGE_BITS'(vin[0][k]);
                    end
                end
            end
            tnb_pkg::S_CROSS:
            begin
                if (!phase_reg)
                begin
                    prod_reg <= mul_a * mul_b;
                end
                else if (!idx_reg[0])
                begin
                    acc_reg <= prod_reg;
                end
                else
                begin
                    cr_reg[idx_reg[2:1]] <= tnb_pkg::CROSS_BITS'(acc_reg - prod_reg);
                end
            end
            tnb_pkg::S_SCALE:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    mag_reg[k] <= tnb_pkg::MAG_BITS'(mag_full[k] >> shift_amt);
                    neg_reg[k] <= cr_reg[k][tnb_pkg::CROSS_BITS-1];
                    if (degen_now)
                    begin
                        normal_reg[k] <= '0;
                    end
                end
                degen_reg <= degen_now;
                acc_reg   <= '0;
            end
            tnb_pkg::S_NSUM, tnb_pkg::S_RSUM:
            begin
                if (!phase_reg)
                begin
                    prod_reg <= mul_a * mul_b;
                end
                else
                begin
                    acc_reg <= acc_reg + prod_reg;
                    if (mul_last)
                    begin
                        sq_rem_reg  <= acc_reg + prod_reg;
                        sq_root_reg <= '0;
                    end
                end
            end
            tnb_pkg::S_NSQRT:
            begin
                sq_rem_reg  <= sq_rem_next;
                sq_root_reg <= sq_root_next;
                if (cnt_reg == '0)
                begin
                    len_reg     <= tnb_pkg::LEN_BITS'(sq_root_next);
                    div_rem_reg <= tnb_pkg::LEN_BITS'(mag_reg[0]);
                    quo_reg     <= '0;
                end
            end
            tnb_pkg::S_DIV:
            begin
                div_rem_reg <= div_diff << 1;
                quo_reg     <= quo_next;
                if (cnt_reg == '0)
                begin
                    normal_reg[idx_reg[1:0]] <= normal_new;
                    quo_reg <= '0;
                    acc_reg <= '0;
                    if (idx_reg != 3'd2)
                    begin
                        div_rem_reg <= tnb_pkg::LEN_BITS'(mag_reg[idx_reg[1:0] + 2'd1]);
                    end
                end
            end
            tnb_pkg::S_RSQRT:
            begin
                sq_rem_reg  <= sq_rem_next;
                sq_root_reg <= sq_root_next;
                if (cnt_reg == '0)
                begin
                    radius_reg <= (sq_root_next[tnb_pkg::ACC_BITS-1:tnb_pkg::RADIUS_BITS] != '0)
                                ? '1 : tnb_pkg::RADIUS_BITS'(sq_root_next);
                end
            end
            default:
            begin
                quo_reg <= quo_reg;
            end
        endcase
    end

    assign normal_x   = normal_reg[0];
    assign normal_y   = normal_reg[1];
    assign normal_z   = normal_reg[2];
    assign degenerate = degen_reg;
    assign center_x   = ctr[0];
    assign center_y   = ctr[1];
    assign center_z   = ctr[2];
    assign radius     = radius_reg;

    `TNB_ASSERT_NOW(degen_zero_normal, out_valid && degenerate, {normal_x, normal_y, normal_z} == '0)
    `TNB_ASSERT_NOW(box_ordered, out_valid, box_low_reg[0] <= box_high_reg[0])
    `TNB_ASSERT_NEXT(accept_starts_cross, in_accept, state_reg == tnb_pkg::S_CROSS && in_stall)
    `TNB_ASSERT_NOW(div_rem_bounded, state_reg == tnb_pkg::S_DIV, (div_rem_reg >> 1) < len_reg)

endmodule
